### hw/rtl/assert_macros.svh
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/ardf_pkg.sv
package ardf_pkg;

   localparam int INDEX_WIDTH_DEF = 16;
   localparam int SIZE_W          = 34;
   localparam int NAME_LEN_W      = 5;
   localparam int NAME_DEPTH      = 16;
   localparam int NAME_ADDR_W     = 4;
   localparam int POS_W           = 6;
   // value, member_size, name_length, error_code, member_last
   localparam int FIXED_BITS      = 8 + SIZE_W + NAME_LEN_W + 2 + 1;

   localparam logic [7:0] CHR_SLASH = 8'h2F;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_GRAVE = 8'h60;
   localparam logic [7:0] CHR_LF    = 8'h0A;

   // header byte positions
   localparam logic [POS_W-1:0] POS_NAME_SECOND = 6'd1;
   localparam logic [POS_W-1:0] POS_NAME_END    = 6'd16;
   localparam logic [POS_W-1:0] POS_SIZE_FIRST  = 6'd48;
   localparam logic [POS_W-1:0] POS_SIZE_END    = 6'd58;
   localparam logic [POS_W-1:0] POS_TERM0       = 6'd58;
   localparam logic [POS_W-1:0] POS_TERM1       = 6'd59;

   typedef enum logic [2:0] {
      KIND_NAME   = 3'd0,
      KIND_HEADER = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_END    = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NOT_ARCHIVE = 2'd0,
      ERR_TERMINATOR  = 2'd1,
      ERR_SIZE        = 2'd2,
      ERR_TRUNCATED   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      LD_NONE,
      LD_DATA,
      LD_NAME,
      LD_HEADER,
      LD_TAIL
   } load_type;

   typedef struct packed {
      logic     accept;
      load_type load;
      logic     run_last;
   } cmd_type;

   typedef struct packed {
      logic step_data;
      logic step_header;
      logic step_tail;
      logic has_name;
      logic name_final;
   } status_type;

   // global magic "!<arch>\n"
   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0: b = 8'h21;
         3'd1: b = 8'h3C;
         3'd2: b = 8'h61;
         3'd3: b = 8'h72;
         3'd4: b = 8'h63;
         3'd5: b = 8'h68;
         3'd6: b = 8'h3E;
         3'd7: b = 8'h0A;
      endcase
      return b;
   endfunction

endpackage

### hw/rtl/ardf_ctrl.sv
module ardf_ctrl import ardf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_RUN,
      S_NAME,
      S_HEADER,
      S_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      tail_ff, tail_in;
   logic      slot_free;
   logic      accept;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_RUN) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      tail_in      = tail_ff;
      cmd.accept   = accept;
      cmd.load     = LD_NONE;
      cmd.run_last = 1'b0;
      unique case (state_ff)
         S_RUN: begin
            if (accept) begin
               tail_in = status.step_tail;
               priority if (status.step_header) begin
                  state_in = status.has_name ? S_NAME : S_HEADER;
               end else if (status.step_data) begin
                  cmd.load     = LD_DATA;
                  cmd.run_last = !status.step_tail;
                  if (status.step_tail) begin
                     state_in = S_TAIL;
                  end
               end else if (status.step_tail) begin
                  cmd.load     = LD_TAIL;
                  cmd.run_last = 1'b1;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_NAME: begin
            if (slot_free) begin
               cmd.load = LD_NAME;
               if (status.name_final) begin
                  state_in = S_HEADER;
               end
            end
         end
         S_HEADER: begin
            if (slot_free) begin
               cmd.load     = LD_HEADER;
               cmd.run_last = !tail_ff;
               state_in     = tail_ff ? S_TAIL : S_RUN;
            end
         end
         S_TAIL: begin
            if (slot_free) begin
               cmd.load     = LD_TAIL;
               cmd.run_last = 1'b1;
               state_in     = S_RUN;
            end
         end
      endcase
      if (cmd.load != LD_NONE) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         valid_ff <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

### hw/rtl/ardf_dp.sv
module ardf_dp import ardf_pkg::*; #(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   output kind_type               out_kind,
   output logic [7:0]             out_value,
   output logic [SIZE_W-1:0]      out_size,
   output logic [NAME_LEN_W-1:0]  out_name_len,
   output logic [INDEX_WIDTH-1:0] out_index,
   output err_type                out_code,
   output logic                   out_member_last,
   output logic                   out_run_last
);

   typedef enum logic [1:0] {
      PH_MAGIC,
      PH_HEADER,
      PH_DATA,
      PH_PAD
   } phase_type;

   typedef enum logic [1:0] {
      DS_NONE,
      DS_RUN,
      DS_DONE,
      DS_BAD
   } digit_type;

   // archive state
   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [NAME_LEN_W-1:0]  klen_ff, klen_in;
   logic                   slash_ff, slash_in;
   logic                   special_ff, special_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   digit_type              digit_ff, digit_in;
   logic                   term_ff, term_in;
   logic [SIZE_W-1:0]      remain_ff, remain_in;
   logic                   pad_ff, pad_in;
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic                   latched_ff, latched_in;

   logic [7:0] name_mem [NAME_DEPTH];

   // header snapshot for name and header items
   logic [SIZE_W-1:0]      rec_size_ff;
   logic [NAME_LEN_W-1:0]  rec_len_ff;
   logic [INDEX_WIDTH-1:0] rec_idx_ff;
   logic [NAME_ADDR_W-1:0] name_idx_ff;
   logic                   tail_err_ff;
   err_type                tail_code_ff;

   // output register
   kind_type               out_kind_ff;
   logic [7:0]             out_value_ff;
   logic [SIZE_W-1:0]      out_size_ff;
   logic [NAME_LEN_W-1:0]  out_len_ff;
   logic [INDEX_WIDTH-1:0] out_idx_ff;
   err_type                out_code_ff;
   logic                   out_mlast_ff;
   logic                   out_run_last_ff;

   logic              step_data, step_header, step_tail, tail_err, restart, mem_we;
   err_type           tail_code;
   logic              is_digit;
   logic [SIZE_W-1:0] size_digit;
   logic [SIZE_W-1:0] remain_dec;
   logic              tail_sel_err;
   err_type           tail_sel_code;

   assign is_digit   = (in_byte >= CHR_ZERO) && (in_byte <= CHR_NINE);
   // acc * 10 + digit as two shifted adds
   assign size_digit = {size_ff[SIZE_W-4:0], 3'b000} + {size_ff[SIZE_W-2:0], 1'b0}
                     + SIZE_W'(in_byte[3:0]);
   assign remain_dec = remain_ff - SIZE_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      klen_in     = klen_ff;
      slash_in    = slash_ff;
      special_in  = special_ff;
      size_in     = size_ff;
      digit_in    = digit_ff;
      term_in     = term_ff;
      remain_in   = remain_ff;
      pad_in      = pad_ff;
      count_in    = count_ff;
      latched_in  = latched_ff;
      step_data   = 1'b0;
      step_header = 1'b0;
      step_tail   = 1'b0;
      tail_err    = 1'b0;
      tail_code   = ERR_NOT_ARCHIVE;
      restart     = 1'b0;
      mem_we      = 1'b0;
      if (cmd.accept) begin
         if (latched_ff) begin
            restart = in_last;
         end else begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  if (in_byte != magic_byte(pos_ff[2:0])) begin
                     step_tail = 1'b1;
                     tail_err  = 1'b1;
                  end else if (pos_ff[2:0] == 3'd7) begin
                     phase_in  = PH_HEADER;
                     pos_in    = '0;
                     step_tail = in_last;
                  end else begin
                     pos_in    = pos_ff + POS_W'(1);
                     step_tail = in_last;
                     tail_err  = 1'b1;
                  end
               end
               PH_HEADER: begin
                  if (pos_ff == '0) begin
                     slash_in   = 1'b0;
                     klen_in    = '0;
                     size_in    = '0;
                     digit_in   = DS_NONE;
                     term_in    = 1'b1;
                     special_in = (in_byte == CHR_SLASH);
                  end else if (pos_ff < POS_NAME_END) begin
                     if (pos_ff == POS_NAME_SECOND) begin
                        special_in = special_ff
                                   && ((in_byte == CHR_SLASH) || (in_byte == CHR_SPACE));
                     end else begin
                        special_in = special_ff && (in_byte == CHR_SPACE);
                     end
                  end
                  // name cut at the first slash, trailing spaces trimmed
                  if ((pos_ff < POS_NAME_END) && !slash_in) begin
                     if (in_byte == CHR_SLASH) begin
                        slash_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        if (in_byte != CHR_SPACE) begin
                           klen_in = pos_ff[NAME_LEN_W-1:0] + NAME_LEN_W'(1);
                        end
                     end
                  end
                  if ((pos_ff >= POS_SIZE_FIRST) && (pos_ff < POS_SIZE_END)) begin
                     unique case (digit_ff)
                        DS_NONE: digit_in = is_digit ? DS_RUN : DS_BAD;
                        DS_RUN: begin
                           if (!is_digit) begin
                              digit_in = DS_DONE;
                           end
                        end
                        DS_DONE, DS_BAD: digit_in = digit_ff;
                     endcase
                     if (is_digit && (digit_in == DS_RUN)) begin
                        size_in = size_digit;
                     end
                  end
                  if (pos_ff == POS_TERM0) begin
                     term_in = term_ff && (in_byte == CHR_GRAVE);
                  end
                  if (pos_ff == POS_TERM1) begin
                     term_in = term_ff && (in_byte == CHR_LF);
                  end
                  priority if (pos_ff != POS_TERM1) begin
                     pos_in    = pos_ff + POS_W'(1);
                     step_tail = in_last;
                     tail_err  = 1'b1;
                     tail_code = ERR_TRUNCATED;
                  end else if (!term_in) begin
                     step_tail = 1'b1;
                     tail_err  = 1'b1;
                     tail_code = ERR_TERMINATOR;
                  end else if ((digit_ff == DS_NONE) || (digit_ff == DS_BAD)) begin
                     step_tail = 1'b1;
                     tail_err  = 1'b1;
                     tail_code = ERR_SIZE;
                  end else if (in_last && (size_ff != '0)) begin
                     step_tail = 1'b1;
                     tail_err  = 1'b1;
                     tail_code = ERR_TRUNCATED;
                  end else begin
                     step_header = !special_ff;
                     remain_in   = size_ff;
                     pad_in      = size_ff[0];
                     pos_in      = '0;
                     if (size_ff != '0) begin
                        phase_in = PH_DATA;
                     end else begin
                        count_in = count_ff + INDEX_WIDTH'(1);
                        phase_in = PH_HEADER;
                     end
                     step_tail = in_last;
                  end
               end
               PH_DATA: begin
                  remain_in = remain_dec;
                  step_data = !special_ff;
                  if (remain_dec == '0) begin
                     if (pad_ff) begin
                        phase_in = PH_PAD;
                     end else begin
                        count_in = count_ff + INDEX_WIDTH'(1);
                        phase_in = PH_HEADER;
                        pos_in   = '0;
                     end
                  end
                  step_tail = in_last;
                  tail_err  = (remain_dec != '0) || pad_ff;
                  tail_code = ERR_TRUNCATED;
               end
               PH_PAD: begin
                  pad_in    = 1'b0;
                  count_in  = count_ff + INDEX_WIDTH'(1);
                  phase_in  = PH_HEADER;
                  pos_in    = '0;
                  step_tail = in_last;
               end
            endcase
            latched_in = step_tail && tail_err && !in_last;
            restart    = step_tail && in_last;
         end
      end
      // new file after the final byte
      if (restart) begin
         phase_in   = PH_MAGIC;
         pos_in     = '0;
         klen_in    = '0;
         slash_in   = 1'b0;
         special_in = 1'b0;
         size_in    = '0;
         digit_in   = DS_NONE;
         term_in    = 1'b1;
         remain_in  = '0;
         pad_in     = 1'b0;
         count_in   = '0;
         latched_in = 1'b0;
      end
   end

   assign status.step_data   = step_data;
   assign status.step_header = step_header;
   assign status.step_tail   = step_tail;
   assign status.has_name    = (klen_ff != '0);
   assign status.name_final  = (({1'b0, name_idx_ff} + NAME_LEN_W'(1)) == rec_len_ff);

   assign tail_sel_err  = cmd.accept ? tail_err : tail_err_ff;
   assign tail_sel_code = cmd.accept ? tail_code : tail_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC;
         pos_ff     <= '0;
         klen_ff    <= '0;
         slash_ff   <= 1'b0;
         special_ff <= 1'b0;
         size_ff    <= '0;
         digit_ff   <= DS_NONE;
         term_ff    <= 1'b1;
         remain_ff  <= '0;
         pad_ff     <= 1'b0;
         count_ff   <= '0;
         latched_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         klen_ff    <= klen_in;
         slash_ff   <= slash_in;
         special_ff <= special_in;
         size_ff    <= size_in;
         digit_ff   <= digit_in;
         term_ff    <= term_in;
         remain_ff  <= remain_in;
         pad_ff     <= pad_in;
         count_ff   <= count_in;
         latched_ff <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[pos_ff[NAME_ADDR_W-1:0]] <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rec_size_ff  <= size_ff;
         rec_len_ff   <= klen_ff;
         rec_idx_ff   <= count_ff;
         tail_err_ff  <= tail_err;
         tail_code_ff <= tail_code;
         name_idx_ff  <= '0;
      end else if (cmd.load == LD_NAME) begin
         name_idx_ff <= name_idx_ff + NAME_ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load != LD_NONE) begin
         out_run_last_ff <= cmd.run_last;
      end
      unique case (cmd.load)
         LD_NONE: begin
         end
         LD_DATA: begin
            out_kind_ff  <= KIND_DATA;
            out_value_ff <= in_byte;
            out_size_ff  <= size_ff;
            out_len_ff   <= klen_ff;
            out_idx_ff   <= count_ff;
            out_code_ff  <= ERR_NOT_ARCHIVE;
            out_mlast_ff <= (remain_dec == '0);
         end
         LD_NAME: begin
            out_kind_ff  <= KIND_NAME;
            out_value_ff <= name_mem[name_idx_ff];
            out_size_ff  <= rec_size_ff;
            out_len_ff   <= rec_len_ff;
            out_idx_ff   <= rec_idx_ff;
            out_code_ff  <= ERR_NOT_ARCHIVE;
            out_mlast_ff <= 1'b0;
         end
         LD_HEADER: begin
            out_kind_ff  <= KIND_HEADER;
            out_value_ff <= '0;
            out_size_ff  <= rec_size_ff;
            out_len_ff   <= rec_len_ff;
            out_idx_ff   <= rec_idx_ff;
            out_code_ff  <= ERR_NOT_ARCHIVE;
            out_mlast_ff <= 1'b0;
         end
         LD_TAIL: begin
            out_kind_ff  <= tail_sel_err ? KIND_ERROR : KIND_END;
            out_value_ff <= '0;
            out_size_ff  <= '0;
            out_len_ff   <= '0;
            out_idx_ff   <= '0;
            out_code_ff  <= tail_sel_err ? tail_sel_code : ERR_NOT_ARCHIVE;
            out_mlast_ff <= 1'b0;
         end
      endcase
   end

   assign out_kind        = out_kind_ff;
   assign out_value       = out_value_ff;
   assign out_size        = out_size_ff;
   assign out_name_len    = out_len_ff;
   assign out_index       = out_idx_ff;
   assign out_code        = out_code_ff;
   assign out_member_last = out_mlast_ff;
   assign out_run_last    = out_run_last_ff;

endmodule

### hw/rtl/ar_archive_member_deframer.sv
// ar archive member deframer
// req channel: one archive byte per item, tlast on the final byte of the file.
// rsp channel: name bytes, one header record and data bytes of each kept member,
//   then archive-end or error items; tuser carries the kind, tlast ends the run
//   of items caused by one input byte.
// magic, header, pad and data bytes are taken as soon as the output register
//   has room. after the byte that closes a kept member's header, no byte is
//   taken while the output sequencer emits its name items and header item (and
//   the end item when the archive ends there). an item that ends in an error or
//   end marker after a data byte likewise holds off the next byte.
// data items are registered from the accepted byte itself, as are end and error
//   items that follow no data or header item of the same byte; the name and
//   header items of a header that closes come from the states entered after it.
// the single-entry output register keeps taking bytes while its item is
//   being taken; while rsp is stalled, req_tready stays low.
// reset clears the parser to expect the global magic and drops any item held.
// an error is reported once; later bytes are swallowed up to the final byte,
//   after which a new file starts. a clean end comes only on the final byte.
`include "assert_macros.svh"

module ar_archive_member_deframer import ardf_pkg::*; #(
   parameter int  INDEX_WIDTH = INDEX_WIDTH_DEF,
   localparam int DATA_W      = FIXED_BITS + INDEX_WIDTH,
   localparam int TDATA_W     = ((DATA_W + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   // byte_value
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               req_tvalid,
   output logic               req_tready,
   // value, member_size, name_length, member_index, error_code, member_last, zero fill
   output logic [TDATA_W-1:0] rsp_tdata,
   // kind
   output logic [2:0]         rsp_tuser,
   output logic               rsp_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready
);

   cmd_type                cmd;
   status_type             status;
   kind_type               out_kind;
   logic [7:0]             out_value;
   logic [SIZE_W-1:0]      out_size;
   logic [NAME_LEN_W-1:0]  out_name_len;
   logic [INDEX_WIDTH-1:0] out_index;
   err_type                out_code;
   logic                   out_member_last;
   logic                   out_run_last;
   logic                   rsp_stalled;
   logic                   rsp_closing;
   logic                   rsp_mlast;

   // sequencer: accepts bytes and orders the items of each one
   ardf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   // parser state, name store and output register
   ardf_dp #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_byte         (req_tdata),
      .in_last         (req_tlast),
      .out_kind        (out_kind),
      .out_value       (out_value),
      .out_size        (out_size),
      .out_name_len    (out_name_len),
      .out_index       (out_index),
      .out_code        (out_code),
      .out_member_last (out_member_last),
      .out_run_last    (out_run_last)
   );

   // pack fields from the lowest bit up, zero fill to whole bytes
   always_comb begin
      rsp_tdata             = '0;
      rsp_tdata[DATA_W-1:0] = {out_member_last, out_code, out_index, out_name_len,
                               out_size, out_value};
   end

   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_run_last;

   // terms for the checks below
   assign rsp_stalled = rsp_tvalid && !rsp_tready;
   assign rsp_closing = rsp_tvalid && ((out_kind == KIND_ERROR) || (out_kind == KIND_END));
   assign rsp_mlast   = rsp_tvalid && out_member_last;

   `ASSERT_IMPLIES(a_stall_blocks_req, clock, reset, rsp_stalled, !req_tready, "byte taken in stall")
   `ASSERT_IMPLIES(a_close_ends_run, clock, reset, rsp_closing, rsp_tlast, "end or error not last")
   `ASSERT_IMPLIES(a_mlast_on_data, clock, reset, rsp_mlast, out_kind == KIND_DATA, "mlast off data")

endmodule
